// ===== hw/rtl/spritz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spritz_pkg;
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_ABSORB = 2'd1,
    OP_STOP   = 2'd2,
    OP_DRIP   = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_NIB_RD_A, S_NIB_RD_B, S_NIB_WR_A, S_NIB_WR_B,
    S_UPD_RD_I, S_UPD_RD_IJ, S_UPD_RD_J, S_UPD_RD_JJ, S_UPD_WR_I, S_UPD_WR_J,
    S_CR_RD_L, S_CR_RD_H, S_CR_WR_L, S_CR_WR_H,
    S_DR_RD_1, S_DR_RD_2, S_DR_RD_3, S_DR_DONE, S_OUT
  } state_e;

  localparam logic [7:0] Half = 8'd128;
  localparam logic [7:0] Last = 8'd255;
  localparam logic [9:0] WhipLast = 10'd511;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/spritz_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spritz_ram (
  input  wire logic               clk_i,
  input  wire spritz_pkg::mem_req_t req_i,
  output logic [7:0]              rdata_o
);
  import spritz_pkg::*;

  logic [7:0] mem_q [256];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/spritz_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spritz_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               out_byte_o,
  output spritz_pkg::mem_req_t     req_o,
  input  wire logic [7:0]          rdata_i
);
  import spritz_pkg::*;

  state_e state_q, state_d;
  logic [7:0] pi_q, pi_d, pj_q, pj_d, pk_q, pk_d, z_q, z_d, a_q, a_d, w_q, w_d;
  logic [7:0] t0_q, t0_d, t1_q, t1_d, cnt8_q, cnt8_d, dat_q, dat_d, ob_q, ob_d;
  logic [9:0] ucnt_q, ucnt_d;
  logic [2:0] phase_q, phase_d; // shuffle step: 0,2,4 whip; 1,3 crush
  logic       shuf_q, shuf_d;   // shuffle active
  logic       nib_q, nib_d;     // second nibble pending
  logic [1:0] op_q, op_d;
  logic       ov_q, ov_d;
  logic       acc;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign out_byte_o = ob_q;

  // sequencer: all datapath and next-state decisions for the operations
  always_comb begin
    pi_d = pi_q; pj_d = pj_q; pk_d = pk_q; z_d = z_q; a_d = a_q; w_d = w_q;
    t0_d = t0_q; t1_d = t1_q; cnt8_d = cnt8_q; dat_d = dat_q; ob_d = ob_q;
    ucnt_d = ucnt_q; phase_d = phase_q; shuf_d = shuf_q; nib_d = nib_q;
    op_d = op_q; ov_d = ov_q;
    req_o = '0;
    state_d = state_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        req_o.we = 1'b1; req_o.waddr = cnt8_q; req_o.wdata = cnt8_q;
        cnt8_d = cnt8_q + 8'd1;
      end
      S_IDLE: if (acc) begin
        op_d = op_i; dat_d = data_i; nib_d = 1'b0;
        if (op_e'(op_i) == OP_INIT) begin
          pi_d = '0; pj_d = '0; pk_d = '0; z_d = '0; a_d = '0; w_d = 8'd1;
          cnt8_d = '0;
        end
      end
      S_DISPATCH: ;
      S_NIB_RD_A: req_o.raddr = a_q;
      S_NIB_RD_B: begin
        t0_d = rdata_i;
        req_o.raddr = Half + {4'd0, nib_q ? dat_q[7:4] : dat_q[3:0]};
      end
      S_NIB_WR_A: begin
        t1_d = rdata_i;
        req_o.we = 1'b1; req_o.waddr = a_q; req_o.wdata = rdata_i;
      end
      S_NIB_WR_B: begin
        req_o.we = 1'b1;
        req_o.waddr = Half + {4'd0, nib_q ? dat_q[7:4] : dat_q[3:0]};
        req_o.wdata = t0_q;
        a_d = a_q + 8'd1;
        nib_d = !nib_q;
      end
      S_UPD_RD_I: req_o.raddr = pi_q;
      S_UPD_RD_IJ: begin
        t0_d = rdata_i;
        req_o.raddr = rdata_i + pj_q;
      end
      S_UPD_RD_J: begin
        pj_d = rdata_i + pk_q;
        req_o.raddr = rdata_i + pk_q;
      end
      S_UPD_RD_JJ: begin
        t1_d = rdata_i;
        pk_d = rdata_i + pk_q + pi_q;
      end
      S_UPD_WR_I: begin
        req_o.we = 1'b1; req_o.waddr = pi_q; req_o.wdata = t1_q;
      end
      S_UPD_WR_J: begin
        req_o.we = 1'b1; req_o.waddr = pj_q; req_o.wdata = t0_q;
      end
      S_CR_RD_L: req_o.raddr = cnt8_q;
      S_CR_RD_H: begin
        t0_d = rdata_i;
        req_o.raddr = Last - cnt8_q;
      end
      S_CR_WR_L: begin
        t1_d = rdata_i;
        if (t0_q > rdata_i) begin
          req_o.we = 1'b1; req_o.waddr = cnt8_q; req_o.wdata = rdata_i;
        end
      end
      S_CR_WR_H: begin
        if (t0_q > t1_q) begin
          req_o.we = 1'b1; req_o.waddr = Last - cnt8_q; req_o.wdata = t0_q;
        end
        cnt8_d = cnt8_q + 8'd1;
      end
      S_DR_RD_1: req_o.raddr = z_q + pk_q;
      S_DR_RD_2: req_o.raddr = pi_q + rdata_i;
      S_DR_RD_3: req_o.raddr = pj_q + rdata_i;
      S_DR_DONE: begin
        z_d = rdata_i;
        ob_d = dat_q ^ rdata_i;
        ov_d = 1'b1;
      end
      S_OUT: ;
      default: ;
    endcase
    // control flow
    unique case (state_q)
      S_CLEAR: if (cnt8_q == Last) state_d = S_IDLE;
      S_IDLE: state_d = acc ? S_DISPATCH : S_IDLE;
      S_DISPATCH: begin
        unique case (op_e'(op_q))
          OP_INIT: state_d = S_CLEAR;
          OP_ABSORB, OP_STOP: begin
            if (a_q == Half) begin
              shuf_d = 1'b1; phase_d = '0; ucnt_d = '0; state_d = S_UPD_RD_I;
              pi_d = pi_q + w_q;
            end else if (op_e'(op_q) == OP_STOP) begin
              a_d = a_q + 8'd1; state_d = S_IDLE;
            end else begin
              state_d = S_NIB_RD_A;
            end
          end
          OP_DRIP: begin
            shuf_d = a_q != 8'd0; phase_d = '0; ucnt_d = '0;
            pi_d = pi_q + w_q;
            state_d = S_UPD_RD_I;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_NIB_RD_A: state_d = S_NIB_RD_B;
      S_NIB_RD_B: state_d = S_NIB_WR_A;
      S_NIB_WR_A: state_d = S_NIB_WR_B;
      S_NIB_WR_B: state_d = nib_q ? S_IDLE : S_DISPATCH;
      S_UPD_RD_I: state_d = S_UPD_RD_IJ;
      S_UPD_RD_IJ: state_d = S_UPD_RD_J;
      S_UPD_RD_J: state_d = S_UPD_RD_JJ;
      S_UPD_RD_JJ: state_d = S_UPD_WR_I;
      S_UPD_WR_I: state_d = S_UPD_WR_J;
      S_UPD_WR_J: begin
        if (!shuf_q) state_d = S_DR_RD_1;
        else if (ucnt_q != WhipLast) begin
          ucnt_d = ucnt_q + 10'd1; pi_d = pi_q + w_q; state_d = S_UPD_RD_I;
        end else begin
          w_d = w_q + 8'd2; ucnt_d = '0;
          if (phase_q == 3'd4) begin
            shuf_d = 1'b0; a_d = '0;
            if (op_e'(op_q) == OP_DRIP) begin
              pi_d = pi_q + w_q + 8'd2; state_d = S_UPD_RD_I;
            end else state_d = S_DISPATCH;
          end else begin
            phase_d = phase_q + 3'd1; cnt8_d = '0; state_d = S_CR_RD_L;
          end
        end
      end
      S_CR_RD_L: state_d = S_CR_RD_H;
      S_CR_RD_H: state_d = S_CR_WR_L;
      S_CR_WR_L: state_d = S_CR_WR_H;
      S_CR_WR_H: begin
        if (cnt8_q == (Half - 8'd1)) begin
          phase_d = phase_q + 3'd1; pi_d = pi_q + w_q; state_d = S_UPD_RD_I;
        end else state_d = S_CR_RD_L;
      end
      S_DR_RD_1: state_d = S_DR_RD_2;
      S_DR_RD_2: state_d = S_DR_RD_3;
      S_DR_RD_3: state_d = S_DR_DONE;
      S_DR_DONE: state_d = S_IDLE;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt8_q <= '0; ov_q <= 1'b0;
      pi_q <= '0; pj_q <= '0; pk_q <= '0; z_q <= '0; a_q <= '0; w_q <= 8'd1;
      ucnt_q <= '0; phase_q <= '0; shuf_q <= 1'b0; nib_q <= 1'b0; op_q <= '0;
    end else begin
      state_q <= state_d; cnt8_q <= cnt8_d; ov_q <= ov_d;
      pi_q <= pi_d; pj_q <= pj_d; pk_q <= pk_d; z_q <= z_d; a_q <= a_d; w_q <= w_d;
      ucnt_q <= ucnt_d; phase_q <= phase_d; shuf_q <= shuf_d; nib_q <= nib_d;
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d; t1_q <= t1_d; dat_q <= dat_d; ob_q <= ob_d;
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_odd_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q[0]) else $error("step even");
  a_a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_q <= 8'd129) else $error("absorb count too large");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(ob_q)) else $error("result lost");
endmodule
`default_nettype wire

// ===== hw/rtl/spritz_sponge_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a drip result becomes valid once its transaction has passed the dispatch, any shuffle,
// the update and the drip read states
// a shuffle adds 1536 updates and 256 crush steps, bounded by the single read and write
// port of the permutation memory
// after reset, and after each init transaction, all 256 entries are rewritten to the identity
// permutation while input is stalled; results wait in an output register
module spritz_sponge_cipher (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o
);
  import spritz_pkg::*;

  mem_req_t   req;
  logic [7:0] rdata;

  spritz_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .data_i,
    .out_valid_o, .out_stall_i, .out_byte_o, .req_o(req), .rdata_i(rdata)
  );

  spritz_ram u_ram (.clk_i, .req_i(req), .rdata_o(rdata));
endmodule
`default_nettype wire
